// ===== src/evas_pkg.sv =====
// ---------------------------------------------------------------------------
// Eased value animation slots: shared package
// Item layouts, kind and reply codes, state types and the request record
// that the slot sequencer hands to the ease arithmetic unit.
// ---------------------------------------------------------------------------
package evas_pkg;

   // Packed widths of the stream payloads, padded to whole bytes.
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 40;

   // Input item kinds, carried on req_tuser.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_STOP  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   // Unused kind, ignored by the block.
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // Result item kinds, carried on rsp_tuser.
   localparam logic [1:0] REPLY_START  = 2'd0;
   localparam logic [1:0] REPLY_STOP   = 2'd1;
   localparam logic [1:0] REPLY_UPDATE = 2'd2;

   // Slot sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REPLY,
      ST_W1_READ,
      ST_W1_UPD,
      ST_W2_READ,
      ST_W2_CALC,
      ST_W2_WAIT,
      ST_W2_EMIT
   } evas_state_type;

   // Ease unit states.
   typedef enum logic [2:0] {
      EASE_IDLE,
      EASE_DIV,
      EASE_SQR,
      EASE_SCALE,
      EASE_SUM,
      EASE_DONE
   } ease_state_type;

   // One slot handed to the ease unit; go launches the computation.
   typedef struct packed {
      logic        go;
      logic [31:0] begin_value;
      logic [31:0] finish_value;
      logic [16:0] elapsed;
      logic [15:0] length;
   } ease_req_type;

endpackage

// ===== src/evas_ease.sv =====
// ---------------------------------------------------------------------------
// Eased value animation slots: ease arithmetic unit
// Computes one quadratic ease-out value for a running slot. A restoring
// divider produces the progress one bit per cycle, then one shared
// multiplier squares the inverse progress and scales the value difference.
// ---------------------------------------------------------------------------
module evas_ease #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  evas_pkg::ease_req_type req,
   output logic                  done,
   output logic [31:0]           value
);
   import evas_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int CNT_W  = $clog2(F + 1);
   localparam int EASE_W = F + 1;
   localparam int PROD_W = 32 + EASE_W;
   localparam logic [EASE_W-1:0] ONE_Q    = EASE_W'(1) << F;
   localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(F - 1);

   ease_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [15:0]         rem_ff, rem_in;
   logic [15:0]         len_ff, len_in;
   logic [F-1:0]        quot_ff, quot_in;
   logic [31:0]         begin_ff, begin_in;
   logic [32:0]         diff_ff, diff_in;
   logic [31:0]         mag_ff, mag_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [31:0]         value_ff, value_in;

   logic [16:0]         rem2;
   logic [16:0]         rem_sub;
   logic                rem_ge;
   logic [32:0]         diff_neg;
   logic [EASE_W-1:0]   inv;
   logic [EASE_W-1:0]   ease;
   logic [31:0]         mul_a;
   logic [EASE_W-1:0]   mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [32:0]         scaled;
   logic [32:0]         scaled_signed;
   logic [32:0]         sum;

   // Divider step: shift the remainder and try to subtract the length.
   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, len_ff};
   assign rem_ge  = rem2 >= {1'b0, len_ff};

   // Magnitude of the value difference.
   assign diff_neg = 33'(0) - diff_ff;

   // Inverse progress and the ease factor taken from the squared inverse.
   assign inv  = ONE_Q - {1'b0, quot_ff};
   assign ease = ONE_Q - prod_ff[2*F:F];

   // The one multiplier, shared between squaring and scaling.
   assign mul_a = (state_ff == EASE_SQR) ? 32'(inv) : mag_ff;
   assign mul_b = (state_ff == EASE_SQR) ? inv : ease;
   assign mul_p = {{EASE_W{1'b0}}, mul_a} * {32'(0), mul_b};

   // Truncate toward zero by scaling the magnitude, then restore the sign.
   assign scaled        = {1'b0, prod_ff[F+31:F]};
   assign scaled_signed = diff_ff[32] ? (33'(0) - scaled) : scaled;
   assign sum           = {begin_ff[31], begin_ff} + scaled_signed;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EASE_IDLE: begin
            if (req.go) begin
               state_in = EASE_DIV;
            end
         end
         EASE_DIV: begin
            if (cnt_ff == LAST_CNT) begin
               state_in = EASE_SQR;
            end
         end
         EASE_SQR:   state_in = EASE_SCALE;
         EASE_SCALE: state_in = EASE_SUM;
         EASE_SUM:   state_in = EASE_DONE;
         EASE_DONE:  state_in = EASE_IDLE;
         default:    state_in = EASE_IDLE;
      endcase
   end

   // Datapath updates for each state.
   always_comb begin
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      quot_in  = quot_ff;
      begin_in = begin_ff;
      diff_in  = diff_ff;
      mag_in   = mag_ff;
      prod_in  = prod_ff;
      value_in = value_ff;
      unique case (state_ff)
         EASE_IDLE: begin
            if (req.go) begin
               cnt_in   = '0;
               rem_in   = req.elapsed[15:0];
               len_in   = req.length;
               quot_in  = '0;
               begin_in = req.begin_value;
               diff_in  = {req.finish_value[31], req.finish_value}
                        - {req.begin_value[31], req.begin_value};
            end
         end
         EASE_DIV: begin
            cnt_in  = cnt_ff + CNT_W'(1);
            rem_in  = rem_ge ? rem_sub[15:0] : rem2[15:0];
            quot_in = {quot_ff[F-2:0], rem_ge};
            mag_in  = diff_ff[32] ? diff_neg[31:0] : diff_ff[31:0];
         end
         EASE_SQR:   prod_in  = mul_p;
         EASE_SCALE: prod_in  = mul_p;
         EASE_SUM:   value_in = sum[31:0];
         EASE_DONE:  ;
         default:    ;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EASE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Arithmetic registers.
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      len_ff   <= len_in;
      quot_ff  <= quot_in;
      begin_ff <= begin_in;
      diff_ff  <= diff_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
   end

   assign done  = (state_ff == EASE_DONE);
   assign value = value_ff;

endmodule

// ===== src/eased_value_animation_slots.sv =====
// ---------------------------------------------------------------------------
// Eased value animation slots
// A table of animation slots that move 32-bit values from a start value to
// an end value with a quadratic ease-out curve, driven by tick items.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  tdata / tuser / tlast
//  req      in         start, end, duration, slot index, delta / kind / -
//  rsp      out        slot, value, granted, finished, any active / kind / last
//
// A start or stop item passes through the reply state, which waits on the result side.
// A tick walks the slots twice: first to add the elapsed time (a read for every
// slot and an update for every active slot), then to produce updates. A running
// slot goes through the read, calc, wait and emit states, waiting on the ease unit
// with its bit-serial divider; a slot that finishes skips the wait state.
// Reset is synchronous and clears the sequencer, the active bits and the result
// register. The block takes no new item until the last result of the current
// one is loaded into the result register.
// ---------------------------------------------------------------------------
module eased_value_animation_slots #(
   parameter int MAX_SLOTS     = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_value[31:0], end_value[63:32], duration[79:64],
   // slot_index[82:80], delta[98:83], zero fill [103:99]
   input  logic [evas_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot[2:0], value[34:3], granted[35], finished[36], any_active[37],
   // zero fill [39:38]
   output logic [evas_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // reply_kind[1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);
   import evas_pkg::*;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

   // Input fields.
   logic [1:0]  req_kind;
   logic [31:0] req_start_value;
   logic [31:0] req_end_value;
   logic [15:0] req_duration;
   logic [2:0]  req_slot_index;
   logic [15:0] req_delta;

   assign req_kind        = req_tuser;
   assign req_start_value = req_tdata[31:0];
   assign req_end_value   = req_tdata[63:32];
   assign req_duration    = req_tdata[79:64];
   assign req_slot_index  = req_tdata[82:80];
   assign req_delta       = req_tdata[98:83];

   // Sequencer and item registers.
   evas_state_type       state_ff, state_in;
   logic [MAX_SLOTS-1:0] active_ff, active_in;
   logic [MAX_SLOTS-1:0] mask_ff, mask_in;
   logic [SLOT_W-1:0]    ptr_ff, ptr_in;
   logic [15:0]          delta_ff, delta_in;
   logic [1:0]           item_kind_ff, item_kind_in;
   logic [2:0]           item_slot_ff, item_slot_in;
   logic                 item_granted_ff, item_granted_in;
   logic [31:0]          res_value_ff, res_value_in;
   logic                 res_finished_ff, res_finished_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;
   logic [2:0]           rsp_slot_ff, rsp_slot_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic                 rsp_finished_ff, rsp_finished_in;
   logic                 rsp_any_ff, rsp_any_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Slot storage, read at the walk pointer.
   logic [31:0]          begin_mem   [MAX_SLOTS];
   logic [31:0]          finish_mem  [MAX_SLOTS];
   logic [15:0]          length_mem  [MAX_SLOTS];
   logic [16:0]          elapsed_mem [MAX_SLOTS];
   logic [31:0]          rd_begin_ff;
   logic [31:0]          rd_finish_ff;
   logic [15:0]          rd_length_ff;
   logic [16:0]          rd_elapsed_ff;

   logic                 accept;
   logic                 out_free;
   logic                 load_out;
   logic                 found_any;
   logic [SLOT_W-1:0]    found_idx;
   logic                 slot_wr;
   logic                 el_wr;
   logic [SLOT_W-1:0]    el_addr;
   logic [16:0]          el_data;
   logic [16:0]          el_sum;
   logic [MAX_SLOTS-1:0] mask_rest;
   ease_req_type         ease_req;
   logic                 ease_done;
   logic [31:0]          ease_value;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign el_sum     = rd_elapsed_ff + {1'b0, delta_ff};
   assign mask_rest  = mask_ff & ~(MAX_SLOTS'(1) << ptr_ff);

   // Lowest free slot.
   always_comb begin
      found_any = 1'b0;
      found_idx = '0;
      for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
         if (!active_ff[j]) begin
            found_any = 1'b1;
            found_idx = SLOT_W'(j);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind inside {KIND_START, KIND_STOP}) begin
                  state_in = ST_REPLY;
               end else if (req_kind == KIND_TICK) begin
                  state_in = ST_W1_READ;
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_W1_READ: begin
            if (mask_ff[ptr_ff]) begin
               state_in = ST_W1_UPD;
            end else if (ptr_ff == LAST_SLOT) begin
               state_in = ST_W2_READ;
            end
         end
         ST_W1_UPD: begin
            state_in = (ptr_ff == LAST_SLOT) ? ST_W2_READ : ST_W1_READ;
         end
         ST_W2_READ: begin
            if (mask_ff == '0) begin
               state_in = ST_IDLE;
            end else if (mask_ff[ptr_ff]) begin
               state_in = ST_W2_CALC;
            end
         end
         ST_W2_CALC: begin
            state_in = active_ff[ptr_ff] ? ST_W2_WAIT : ST_W2_EMIT;
         end
         ST_W2_WAIT: begin
            if (ease_done) begin
               state_in = ST_W2_EMIT;
            end
         end
         ST_W2_EMIT: begin
            if (out_free) begin
               state_in = (mask_rest == '0) ? ST_IDLE : ST_W2_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: slot updates, item registers and results.
   always_comb begin
      active_in       = active_ff;
      mask_in         = mask_ff;
      ptr_in          = ptr_ff;
      delta_in        = delta_ff;
      item_kind_in    = item_kind_ff;
      item_slot_in    = item_slot_ff;
      item_granted_in = item_granted_ff;
      res_value_in    = res_value_ff;
      res_finished_in = res_finished_ff;
      slot_wr         = 1'b0;
      el_wr           = 1'b0;
      el_addr         = ptr_ff;
      el_data         = el_sum;
      ease_req        = '{go: 1'b0, begin_value: rd_begin_ff, finish_value: rd_finish_ff,
                          elapsed: rd_elapsed_ff, length: rd_length_ff};
      load_out        = 1'b0;
      rsp_kind_in     = REPLY_UPDATE;
      rsp_slot_in     = 3'(ptr_ff);
      rsp_value_in    = res_value_ff;
      rsp_granted_in  = 1'b0;
      rsp_finished_in = res_finished_ff;
      rsp_any_in      = |active_ff;
      rsp_last_in     = (mask_rest == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_START: begin
                     item_kind_in    = REPLY_START;
                     item_granted_in = found_any;
                     item_slot_in    = found_any ? 3'(found_idx) : 3'd0;
                     if (found_any) begin
                        active_in[found_idx] = 1'b1;
                        slot_wr              = 1'b1;
                        el_wr                = 1'b1;
                        el_addr              = found_idx;
                        el_data              = '0;
                     end
                  end
                  KIND_STOP: begin
                     item_kind_in    = REPLY_STOP;
                     item_granted_in = 1'b0;
                     item_slot_in    = req_slot_index;
                     for (int j = 0; j < MAX_SLOTS; j++) begin
                        if (int'(req_slot_index) == j) begin
                           active_in[j] = 1'b0;
                        end
                     end
                  end
                  KIND_TICK: begin
                     mask_in  = active_ff;
                     delta_in = req_delta;
                     ptr_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_REPLY: begin
            load_out        = out_free;
            rsp_kind_in     = item_kind_ff;
            rsp_slot_in     = item_slot_ff;
            rsp_value_in    = '0;
            rsp_granted_in  = item_granted_ff;
            rsp_finished_in = 1'b0;
            rsp_last_in     = 1'b1;
         end
         ST_W1_READ: begin
            if (!mask_ff[ptr_ff]) begin
               ptr_in = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + SLOT_W'(1);
            end
         end
         ST_W1_UPD: begin
            // Add the tick time and retire the slot once it reaches its length.
            el_wr  = 1'b1;
            ptr_in = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + SLOT_W'(1);
            if (el_sum >= {1'b0, rd_length_ff}) begin
               active_in[ptr_ff] = 1'b0;
            end
         end
         ST_W2_READ: begin
            if (mask_ff != '0 && !mask_ff[ptr_ff]) begin
               ptr_in = ptr_ff + SLOT_W'(1);
            end
         end
         ST_W2_CALC: begin
            // A slot retired in the first walk reports its end value.
            if (active_ff[ptr_ff]) begin
               ease_req.go     = 1'b1;
               res_finished_in = 1'b0;
            end else begin
               res_value_in    = rd_finish_ff;
               res_finished_in = 1'b1;
            end
         end
         ST_W2_WAIT: begin
            if (ease_done) begin
               res_value_in = ease_value;
            end
         end
         ST_W2_EMIT: begin
            load_out = out_free;
            if (out_free) begin
               mask_in = mask_rest;
               if (mask_rest != '0) begin
                  ptr_in = ptr_ff + SLOT_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // Result register handshake.
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Shared ease arithmetic.
   evas_ease #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ease (
      .clock (clock),
      .reset (reset),
      .req   (ease_req),
      .done  (ease_done),
      .value (ease_value)
   );

   // Slot storage writes and the registered read at the walk pointer.
   always_ff @(posedge clock) begin
      if (slot_wr) begin
         begin_mem[found_idx]  <= req_start_value;
         finish_mem[found_idx] <= req_end_value;
         length_mem[found_idx] <= req_duration;
      end
      if (el_wr) begin
         elapsed_mem[el_addr] <= el_data;
      end
      rd_begin_ff   <= begin_mem[ptr_ff];
      rd_finish_ff  <= finish_mem[ptr_ff];
      rd_length_ff  <= length_mem[ptr_ff];
      rd_elapsed_ff <= elapsed_mem[ptr_ff];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         mask_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         mask_ff      <= mask_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      delta_ff        <= delta_in;
      item_kind_ff    <= item_kind_in;
      item_slot_ff    <= item_slot_in;
      item_granted_ff <= item_granted_in;
      res_value_ff    <= res_value_in;
      res_finished_ff <= res_finished_in;
      if (load_out) begin
         rsp_kind_ff     <= rsp_kind_in;
         rsp_slot_ff     <= rsp_slot_in;
         rsp_value_ff    <= rsp_value_in;
         rsp_granted_ff  <= rsp_granted_in;
         rsp_finished_ff <= rsp_finished_in;
         rsp_any_ff      <= rsp_any_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_any_ff, rsp_finished_ff, rsp_granted_ff,
                        rsp_value_ff, rsp_slot_ff};

   // The ease unit only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      ease_done |-> state_ff == ST_W2_WAIT)
      else $error("ease unit finished outside the wait state");

   // During the first walk every active slot belongs to the tick's slot set.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W1_READ || state_ff == ST_W1_UPD) |-> (active_ff & ~mask_ff) == '0)
      else $error("slot active outside the tick's slot set");

   // A finished update always refers to a slot that has been freed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W2_EMIT && load_out && res_finished_ff) |-> !active_ff[ptr_ff])
      else $error("finished update for a slot that is still active");

   // After the last result of a tick the sequencer is back to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_W2_EMIT && load_out && rsp_last_in) |=> state_ff == ST_IDLE)
      else $error("tick did not end after its last result");

endmodule

// ===== tb/eased_value_animation_slots_tb.sv =====
// ---------------------------------------------------------------------------
// Eased value animation slots: testbench
// Drives start, stop, tick and unused-kind items into the slot table and checks every
// result item against a cycle-free prediction of the slot state and the
// quadratic ease-out arithmetic. Both stream sides idle at random, and the
// result side holds off for long stretches so the block backs up its input.
// ---------------------------------------------------------------------------
module eased_value_animation_slots_tb;
   import evas_pkg::*;

   localparam int SLOT_COUNT = 8;
   localparam int FRAC_BITS  = 16;
   localparam longint ONE_Q  = longint'(1) << FRAC_BITS;

   // One result item as it travels on the result channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic [31:0] value;
      logic        granted;
      logic        finished;
      logic        any_active;
      logic        last;
   } reply_item_type;

   // Tracks the slot table and holds the result items still owed by the block.
   class tween_table_tracker;
      logic           active[SLOT_COUNT];
      logic [31:0]    begin_v[SLOT_COUNT];
      logic [31:0]    finish_v[SLOT_COUNT];
      logic [15:0]    length[SLOT_COUNT];
      logic [16:0]    elapsed[SLOT_COUNT];
      reply_item_type awaited_replies[$];
      int             mismatch_count;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            active[i] = 1'b0;
         end
         mismatch_count = 0;
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         mismatch_count++;
      endtask

      function int pending();
         return awaited_replies.size();
      endfunction

      // Quadratic ease-out between two values at elapsed / length.
      function logic [31:0] ease_out_value(logic [31:0] b, logic [31:0] f,
                                           logic [16:0] el, logic [15:0] len);
         longint prog;
         longint inv;
         longint ease;
         longint sb;
         longint sf;
         longint scaled;
         prog   = (longint'(el) << FRAC_BITS) / longint'(len);
         inv    = ONE_Q - prog;
         ease   = ONE_Q - ((inv * inv) >> FRAC_BITS);
         sb     = longint'($signed(b));
         sf     = longint'($signed(f));
         // Signed division truncates toward zero.
         scaled = ((sf - sb) * ease) / ONE_Q;
         return 32'(sb + scaled);
      endfunction

      // Updates the slot table for an accepted input item and queues its results.
      function void note_request(logic [1:0] kind, logic [REQ_DATA_W-1:0] data);
         reply_item_type batch[$];
         reply_item_type r;
         logic [16:0]    el;
         logic [2:0]     idx;
         logic           busy;
         int             found;
         int             i;
         found = -1;
         batch = {};
         case (kind)
            KIND_START: begin
               for (i = 0; i < SLOT_COUNT; i++) begin
                  if (!active[i] && found < 0) found = i;
               end
               r = '0;
               r.kind = REPLY_START;
               if (found >= 0) begin
                  active[found]   = 1'b1;
                  begin_v[found]  = data[31:0];
                  finish_v[found] = data[63:32];
                  length[found]   = data[79:64];
                  elapsed[found]  = '0;
                  r.slot          = 3'(found);
                  r.granted       = 1'b1;
               end
               batch.push_back(r);
            end
            KIND_STOP: begin
               idx = data[82:80];
               active[idx] = 1'b0;
               r = '0;
               r.kind = REPLY_STOP;
               r.slot = idx;
               batch.push_back(r);
            end
            KIND_TICK: begin
               for (i = 0; i < SLOT_COUNT; i++) begin
                  if (active[i]) begin
                     el = elapsed[i] + {1'b0, data[98:83]};
                     elapsed[i] = el;
                     r = '0;
                     r.kind = REPLY_UPDATE;
                     r.slot = 3'(i);
                     if (el >= {1'b0, length[i]}) begin
                        active[i]  = 1'b0;
                        r.value    = finish_v[i];
                        r.finished = 1'b1;
                     end else begin
                        r.value = ease_out_value(begin_v[i], finish_v[i], el, length[i]);
                     end
                     batch.push_back(r);
                  end
               end
            end
            default: ;
         endcase
         // Activity flag reflects the table after the whole item.
         busy = 1'b0;
         for (i = 0; i < SLOT_COUNT; i++) begin
            busy = busy | active[i];
         end
         for (i = 0; i < batch.size(); i++) begin
            r = batch[i];
            r.any_active = busy;
            r.last = (i == batch.size() - 1);
            awaited_replies.push_back(r);
         end
      endfunction

      task compare_field(string name, longint unsigned got, longint unsigned exp);
         if (got !== exp) begin
            report($sformatf("%s: got %0h, expected %0h", name, got, exp));
         end
      endtask

      // Checks an accepted result item against the oldest queued one.
      task check_reply(logic [1:0] kind, logic [RSP_DATA_W-1:0] data, logic last_flag);
         reply_item_type exp;
         if (awaited_replies.size() == 0) begin
            report($sformatf("unexpected result kind %0d slot %0d value %0h",
                             kind, data[2:0], data[34:3]));
            return;
         end
         exp = awaited_replies.pop_front();
         compare_field("reply kind", kind, exp.kind);
         compare_field("slot", data[2:0], exp.slot);
         compare_field("value", data[34:3], exp.value);
         compare_field("granted", data[35], exp.granted);
         compare_field("finished", data[36], exp.finished);
         compare_field("any active", data[37], exp.any_active);
         compare_field("last", last_flag, exp.last);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   // start_value, end_value, duration, slot_index, delta, zero fill
   logic [REQ_DATA_W-1:0] req_tdata;
   // kind
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // slot, value, granted, finished, any_active, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // reply_kind
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   tween_table_tracker tracker = new();
   bit                 no_idle = 1'b0;

   eased_value_animation_slots u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 4);
   endfunction

   // Offers one item after a random gap and waits until the block takes it.
   task automatic send_item(logic [1:0] kind, logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(kind, data);
   endtask

   // Fields that an item's kind does not use carry random junk.
   task automatic issue_start(logic [31:0] s, logic [31:0] e, logic [15:0] dur);
      send_item(KIND_START, {5'd0, 16'($urandom), 3'($urandom), dur, e, s});
   endtask

   task automatic issue_stop(logic [2:0] idx);
      send_item(KIND_STOP, {5'd0, 16'($urandom), idx, 16'($urandom), $urandom, $urandom});
   endtask

   task automatic issue_tick(logic [15:0] delta);
      send_item(KIND_TICK, {5'd0, delta, 3'($urandom), 16'($urandom), $urandom, $urandom});
   endtask

   // Unused kind; the block must ignore it.
   task automatic issue_noise();
      send_item(KIND_NONE, {5'd0, 16'($urandom), 3'($urandom), 16'($urandom), $urandom,
                            $urandom});
   endtask

   // Result side: random stalls, with a long hold-off now and then.
   initial begin : reply_sink
      int wait_cycles;
      int seen;
      seen = 0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (seen % 150 == 60) wait_cycles = 300;
         else wait_cycles = draw_gap();
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_reply(rsp_tuser, rsp_tdata, rsp_tlast);
         seen++;
      end
   end

   // Stimulus: directed corner cases, then random traffic.
   initial begin : stimulus
      int issued;
      int pick;
      logic [31:0] sv;
      logic [31:0] ev;
      logic [15:0] dur;
      req_tvalid <= 1'b0;
      req_tuser  <= KIND_START;
      req_tdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Tick on an empty table gives nothing; the unused kind is ignored.
      issue_tick(16'd100);
      issue_noise();
      // Fill every slot, with extreme values and lengths.
      issue_start(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
      issue_start(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
      issue_start(32'd5, -32'sd5, 16'd0);
      issue_start($urandom, $urandom, 16'd1000);
      repeat (4) issue_start($urandom, $urandom, 16'($urandom_range(2, 500)));
      // Table full: the start is refused.
      issue_start($urandom, $urandom, 16'd10);
      issue_stop(3'd7);
      // Zero length finishes on a zero tick; length one on the next.
      issue_tick(16'd0);
      issue_tick(16'd1);
      // Stop of an idle slot is only acknowledged.
      issue_stop(3'd2);
      issue_tick(16'hFFFF);
      // Finish exactly at the length.
      issue_start(32'hFFFF_FFFF, 32'd0, 16'hFFFF);
      issue_tick(16'h7FFF);
      issue_tick(16'h8000);
      issue_start(32'd0, 32'hFFFF_FFFF, 16'd40);
      issue_stop(3'd0);
      issue_tick(16'd3);

      // Random traffic, mostly well-formed lifetimes with random content.
      issued = 0;
      while (issued < 85) begin
         no_idle = (issued >= 40 && issued < 60);
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            issue_noise();
         end else if (pick < 40) begin
            sv = $urandom;
            ev = $urandom;
            if ($urandom_range(0, 7) == 0) sv = {$urandom_range(0, 1) == 0, {31{sv[0]}}};
            if ($urandom_range(0, 7) == 0) ev = {$urandom_range(0, 1) == 0, {31{ev[0]}}};
            pick = $urandom_range(0, 9);
            if (pick == 0) dur = 16'd0;
            else if (pick == 1) dur = 16'($urandom);
            else dur = 16'($urandom_range(1, 300));
            issue_start(sv, ev, dur);
            issued++;
         end else if (pick < 52) begin
            issue_stop(3'($urandom_range(0, 7)));
            issued++;
         end else begin
            if ($urandom_range(0, 9) == 0) issue_tick(16'($urandom));
            else issue_tick(16'($urandom_range(0, 60)));
            issued++;
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Run limit.
   initial begin : watchdog
      #1600000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
src/evas_pkg.sv
src/evas_ease.sv
src/eased_value_animation_slots.sv
tb/eased_value_animation_slots_tb.sv
